/* design/eabt_pkg.sv */
// Shared constants, command codes and controller/datapath interface types
// for the expiring address ban table. No dependencies.
`default_nettype none
package eabt_pkg;

	localparam int ADDR_W = 48;
	localparam int SECS_W = 20;
	localparam int TIME_W = 31;
	localparam int SLOT_W = 4;
	localparam int PROD_W = 30;

	localparam logic [9:0] MS_PER_SEC = 10'd1000;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic CMD_BAN   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture the incoming word, restart the scan
		logic rd_en;     // read one slot and advance the scan pointer
		logic commit;    // write the chosen slot
		logic out_load;  // capture the result word
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic rd_last;   // scan pointer sits on the last slot
		logic is_query;  // held word is a query
	} sts_t;

endpackage
`default_nettype wire

/* design/expiring_address_ban_table_core.sv */
// Top level of the expiring address ban table: ties the controller to the
// datapath. Depends on eabt_pkg, eabt_ctrl and eabt_dpath.
//
// The block keeps TABLE_SLOTS entries of a 48-bit address and a 31-bit expiry
// time in milliseconds; reset frees every slot at once through per-slot valid
// bits, so no clearing pass is needed. Each accepted word (cmd, address,
// ban_seconds, now_ms) gives exactly one result word. A ban (cmd 0) writes the
// lowest slot whose expiry is zero or before now_ms, or, if none is free, the
// slot with the earliest expiry (lowest index on a tie, evicted set). The new
// expiry is now_ms + ban_seconds * 1000, saturated at 2^31-1. slot_used
// reports the low four bits of the slot written. A query (cmd 1) sets banned
// when an entry with a nonzero expiry later than now_ms holds the address.
// Fields not used by a command read as zero. One word is in flight at a time:
// the scan reads one slot per cycle from the single read port of the slot
// memory, then a drain state, for a ban a write-back state, and a response
// state that loads the output register. The next word can be accepted in the
// same cycle as the result appears. A finished result waits in the output
// register while the next word is accepted; a stalled result delays only the
// hand-off of the following one.
`default_nettype none
module expiring_address_ban_table_core #(
	parameter int TABLE_SLOTS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         cmd,
	input  wire logic [eabt_pkg::ADDR_W-1:0]  address,
	input  wire logic [eabt_pkg::SECS_W-1:0]  ban_seconds,
	input  wire logic [eabt_pkg::TIME_W-1:0]  now_ms,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              banned,
	output logic [eabt_pkg::SLOT_W-1:0]       slot_used,
	output logic                              evicted
);

	eabt_pkg::ctl_t ctl;
	eabt_pkg::sts_t sts;

	// sequence one word at a time through scan, write-back and hand-off
	eabt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// hold the table, scan it and build the result word
	eabt_dpath #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cmd         (cmd),
		.address     (address),
		.ban_seconds (ban_seconds),
		.now_ms      (now_ms),
		.banned      (banned),
		.slot_used   (slot_used),
		.evicted     (evicted)
	);

	// a word just taken must block the next one while it is scanned
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted again right after an accept");

	// a query result never carries ban fields
	a_query_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && banned) |-> (slot_used == '0) && !evicted)
		else $error("banned set together with ban fields");

	// a new result only appears while the table is busy with a word
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result word appeared without a word in progress");

endmodule
`default_nettype wire

/* design/eabt_ctrl.sv */
// Controller state machine for the ban table: sequences accept, slot scan,
// write-back and result hand-off. Depends on eabt_pkg.
`default_nettype none
module eabt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire eabt_pkg::sts_t sts,
	output eabt_pkg::ctl_t     ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_WRITE,
		S_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_IDLE:  ctl.load = in_valid;
			S_SCAN:  ctl.rd_en = 1'b1;
			S_DRAIN: ;
			S_WRITE: ctl.commit = 1'b1;
			S_RESP:  ctl.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.rd_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= sts.is_query ? S_RESP : S_WRITE;
				end
				S_WRITE: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* design/eabt_dpath.sv */
// Datapath for the ban table: slot memories with valid bits, scan pointer,
// compare/oldest-tracking stage, expiry arithmetic, result registers.
// Depends on eabt_pkg.
`default_nettype none
module eabt_dpath #(
	parameter int TABLE_SLOTS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire eabt_pkg::ctl_t               ctl,
	output eabt_pkg::sts_t                    sts,
	input  wire logic                         cmd,
	input  wire logic [eabt_pkg::ADDR_W-1:0]  address,
	input  wire logic [eabt_pkg::SECS_W-1:0]  ban_seconds,
	input  wire logic [eabt_pkg::TIME_W-1:0]  now_ms,
	output logic                              banned,
	output logic [eabt_pkg::SLOT_W-1:0]       slot_used,
	output logic                              evicted
);

	localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

	// held request word
	logic                        cmd_q;
	logic [eabt_pkg::ADDR_W-1:0] addr_q;
	logic [eabt_pkg::TIME_W-1:0] now_q;
	logic [eabt_pkg::PROD_W-1:0] prod_q;
	logic [eabt_pkg::TIME_W-1:0] exp_new_q;
	logic [eabt_pkg::TIME_W:0]   exp_sum;

	// slot storage
	logic [eabt_pkg::ADDR_W-1:0] addr_mem [TABLE_SLOTS];
	logic [eabt_pkg::TIME_W-1:0] exp_mem  [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0]      valid_q;

	// scan
	logic [IW-1:0]               rd_idx_q;
	logic                        vld_s1;
	logic [IW-1:0]               idx_s1;
	logic [eabt_pkg::ADDR_W-1:0] addr_s1;
	logic [eabt_pkg::TIME_W-1:0] mem_exp_s1;
	logic                        slot_valid_s1;
	logic [eabt_pkg::TIME_W-1:0] exp_s1;

	// scan accumulators
	logic                        hit_q;
	logic                        free_q;
	logic [IW-1:0]               free_idx_q;
	logic [IW-1:0]               old_idx_q;
	logic [eabt_pkg::TIME_W-1:0] old_time_q;

	logic                        first;
	logic                        live;
	logic                        match;
	logic                        free;
	logic [IW-1:0]               wr_idx;

	logic                        banned_q;
	logic [eabt_pkg::SLOT_W-1:0] slot_q;
	logic                        evicted_q;

	assign sts.rd_last  = (rd_idx_q == LAST_IDX);
	assign sts.is_query = (cmd_q == eabt_pkg::CMD_QUERY);

	assign exp_sum = {1'b0, now_q} + (eabt_pkg::TIME_W + 1)'(prod_q);

	// an entry never written reads as a free slot
	assign exp_s1 = slot_valid_s1 ? mem_exp_s1 : '0;
	assign first  = (idx_s1 == '0);
	assign live   = (exp_s1 != '0) && (exp_s1 > now_q);
	assign match  = live && (addr_s1 == addr_q);
	assign free   = (exp_s1 == '0) || (exp_s1 < now_q);
	assign wr_idx = free_q ? free_idx_q : old_idx_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			addr_q <= address;
			now_q  <= now_ms;
			prod_q <= eabt_pkg::PROD_W'(ban_seconds) * eabt_pkg::PROD_W'(eabt_pkg::MS_PER_SEC);
		end
		// saturate at the top of the time range
		exp_new_q <= exp_sum[eabt_pkg::TIME_W] ? eabt_pkg::TIME_MAX
		                                       : exp_sum[eabt_pkg::TIME_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			addr_mem[wr_idx] <= addr_q;
			exp_mem[wr_idx]  <= exp_new_q;
		end
		if (ctl.rd_en) begin
			addr_s1       <= addr_mem[rd_idx_q];
			mem_exp_s1    <= exp_mem[rd_idx_q];
			slot_valid_s1 <= valid_q[rd_idx_q];
			idx_s1        <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_s1   <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			vld_s1 <= ctl.rd_en;
			if (ctl.commit) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (ctl.load) begin
				rd_idx_q <= '0;
			end else if (ctl.rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// compare stage: keep first match, first free slot, earliest expiry
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			hit_q <= first ? match : (hit_q | match);
			if (first || (!free_q && free)) begin
				free_q     <= free;
				free_idx_q <= idx_s1;
			end
			if (first || (exp_s1 < old_time_q)) begin
				old_time_q <= exp_s1;
				old_idx_q  <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			banned_q  <= sts.is_query && hit_q;
			slot_q    <= sts.is_query ? '0 : eabt_pkg::SLOT_W'(wr_idx);
			evicted_q <= !sts.is_query && !free_q;
		end
	end

	assign banned    = banned_q;
	assign slot_used = slot_q;
	assign evicted   = evicted_q;

endmodule
`default_nettype wire

/* verif/tb_expiring_address_ban_table_core.sv */
// Self-checking testbench for expiring_address_ban_table_core: directed ban/query
// words, then random traffic under three idle/stall profiles, checked against a
// local model of the slot table. Depends on eabt_pkg and the core.
`default_nettype none
module tb_expiring_address_ban_table_core;

	localparam int SLOTS       = 16;
	localparam int RANDOM_REQS = 1900;
	localparam int CYCLE_LIMIT = 500000;
	localparam int POOL_SIZE   = 8;
	localparam logic [eabt_pkg::SECS_W-1:0] SECS_MAX = {eabt_pkg::SECS_W{1'b1}};
	localparam logic [eabt_pkg::ADDR_W-1:0] ADDR_MAX = {eabt_pkg::ADDR_W{1'b1}};

	// One result word as the block presents it.
	typedef struct packed {
		logic                          banned;
		logic [eabt_pkg::SLOT_W-1:0]   slot_used;
		logic                          evicted;
	} verdict_t;

	// Shadow of the slot table plus the verdicts still owed by the block.
	class ban_table_tracker;
		logic [eabt_pkg::ADDR_W-1:0] address [SLOTS];
		logic [eabt_pkg::TIME_W-1:0] expiry [SLOTS];
		verdict_t                    pending_verdicts [$];
		int                          mismatches;

		function new();
			foreach (address[i]) begin
				address[i] = '0;
				expiry[i]  = '0;
			end
			mismatches = 0;
		endfunction

		function logic [eabt_pkg::TIME_W-1:0] expiry_after(
				logic [eabt_pkg::TIME_W-1:0] t, logic [eabt_pkg::SECS_W-1:0] s);
			logic [63:0] sum;
			sum = 64'(t) + 64'(s) * 64'd1000;
			if (sum > 64'(eabt_pkg::TIME_MAX))
				return eabt_pkg::TIME_MAX;
			return sum[eabt_pkg::TIME_W-1:0];
		endfunction

		// Compute the verdict for one request and apply its effect on the table.
		function verdict_t predict_verdict(logic c, logic [eabt_pkg::ADDR_W-1:0] a,
				logic [eabt_pkg::SECS_W-1:0] s, logic [eabt_pkg::TIME_W-1:0] t);
			verdict_t v;
			int       victim;
			v = '0;
			if (c == eabt_pkg::CMD_QUERY) begin
				foreach (expiry[i])
					if (expiry[i] != '0 && expiry[i] > t && address[i] == a)
						v.banned = 1'b1;
				return v;
			end
			victim = -1;
			foreach (expiry[i])
				if (victim < 0 && (expiry[i] == '0 || expiry[i] < t))
					victim = i;
			if (victim < 0) begin
				// table full: earliest expiry goes, lowest index on a tie
				v.evicted = 1'b1;
				victim = 0;
				for (int i = 1; i < SLOTS; i++)
					if (expiry[i] < expiry[victim])
						victim = i;
			end
			address[victim] = a;
			expiry[victim]  = expiry_after(t, s);
			v.slot_used = victim[eabt_pkg::SLOT_W-1:0];
			return v;
		endfunction

		function void note_request(logic c, logic [eabt_pkg::ADDR_W-1:0] a,
				logic [eabt_pkg::SECS_W-1:0] s, logic [eabt_pkg::TIME_W-1:0] t);
			pending_verdicts.push_back(predict_verdict(c, a, s, t));
		endfunction

		function void check_verdict(logic b, logic [eabt_pkg::SLOT_W-1:0] slot, logic ev);
			verdict_t want;
			if (pending_verdicts.size() == 0) begin
				$error("result word with nothing outstanding: banned %0d slot_used %0d evicted %0d",
					b, slot, ev);
				mismatches++;
				return;
			end
			want = pending_verdicts.pop_front();
			if (b !== want.banned) begin
				$error("banned: expected %0d, got %0d", want.banned, b);
				mismatches++;
			end
			if (slot !== want.slot_used) begin
				$error("slot_used: expected %0d, got %0d", want.slot_used, slot);
				mismatches++;
			end
			if (ev !== want.evicted) begin
				$error("evicted: expected %0d, got %0d", want.evicted, ev);
				mismatches++;
			end
		endfunction

		function int pending();
			return pending_verdicts.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic cmd;
	logic [eabt_pkg::ADDR_W-1:0] address;
	logic [eabt_pkg::SECS_W-1:0] ban_seconds;
	logic [eabt_pkg::TIME_W-1:0] now_ms;
	logic out_valid;
	logic out_stall;
	logic banned;
	logic [eabt_pkg::SLOT_W-1:0] slot_used;
	logic evicted;

	ban_table_tracker            tracker;
	int                          idle_pct;    // sender: chance of an empty cycle before a word
	int                          stall_pct;   // receiver: chance of stalling on any cycle
	int                          cycles;
	logic [eabt_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];
	logic [eabt_pkg::TIME_W-1:0] clock_ms;    // running notion of server time

	expiring_address_ban_table_core #(
		.TABLE_SLOTS(SLOTS)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.address    (address),
		.ban_seconds(ban_seconds),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.banned     (banned),
		.slot_used  (slot_used),
		.evicted    (evicted)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop in case the block hangs on a handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: values read here are the ones that held at the edge, so a word
	// counts as taken exactly when the block sees valid high and stall low.
	// Draw a fresh stall decision every cycle from the current profile.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_verdict(banned, slot_used, evicted);
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Present one request word and hold it until the block takes it. Called right
	// after a rising edge; each step touches in_valid only once.
	task automatic send_word(input logic c, input logic [eabt_pkg::ADDR_W-1:0] a,
			input logic [eabt_pkg::SECS_W-1:0] s, input logic [eabt_pkg::TIME_W-1:0] t);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= c;
		address     <= a;
		ban_seconds <= s;
		now_ms      <= t;
		do
			@(posedge clk);
		while (in_stall);
		tracker.note_request(c, a, s, t);
	endtask

	// Advance server time: mostly small forward steps, sometimes a jump anywhere
	// in the range, sometimes straight onto a stored expiry so the "equal to now"
	// boundary gets hit on both bans and queries.
	task automatic advance_clock();
		int roll;
		int step;
		roll = $urandom_range(0, 99);
		step = $urandom_range(0, 2500);
		if (roll < 3)
			clock_ms = eabt_pkg::TIME_W'($urandom());
		else if (roll < 9)
			clock_ms = tracker.expiry[$urandom_range(0, SLOTS - 1)];
		else if (clock_ms > eabt_pkg::TIME_MAX - eabt_pkg::TIME_W'(step))
			clock_ms = eabt_pkg::TIME_W'($urandom_range(0, 100000));
		else
			clock_ms = clock_ms + eabt_pkg::TIME_W'(step);
	endtask

	// One random request. Addresses mostly come from a small pool so queries
	// actually hit live entries and bans compete for slots; ban lengths are
	// mostly short so entries age out while traffic continues.
	task automatic random_request();
		logic                        c;
		logic [eabt_pkg::ADDR_W-1:0] a;
		logic [eabt_pkg::SECS_W-1:0] s;
		int                          roll;
		advance_clock();
		c = ($urandom_range(0, 1) == 0) ? eabt_pkg::CMD_BAN : eabt_pkg::CMD_QUERY;
		if ($urandom_range(0, 99) < 85)
			a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			a = {$urandom(), 16'($urandom())};
		roll = $urandom_range(0, 99);
		if (roll < 70)
			s = eabt_pkg::SECS_W'($urandom_range(0, 20));
		else if (roll < 90)
			s = eabt_pkg::SECS_W'($urandom_range(0, 600));
		else
			s = eabt_pkg::SECS_W'($urandom());
		// now and then swap a pool entry so stale addresses drift out
		if ($urandom_range(0, 99) < 2)
			addr_pool[$urandom_range(0, POOL_SIZE - 1)] = {$urandom(), 16'($urandom())};
		send_word(c, a, s, clock_ms);
	endtask

	initial begin
		tracker     = new();
		cycles      = 0;
		idle_pct    = 22;
		stall_pct   = 59;
		clock_ms    = '0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		cmd         <= eabt_pkg::CMD_BAN;
		address     <= '0;
		ban_seconds <= '0;
		now_ms      <= '0;
		out_stall   <= 1'b0;

		// Pool: entries 0 and 1 share one IP and differ in port only, entry 2 shares only the port, to catch partial matches.
		foreach (addr_pool[i])
			addr_pool[i] = {$urandom(), 16'($urandom())};
		addr_pool[1] = {addr_pool[0][eabt_pkg::ADDR_W-1:16], ~addr_pool[0][15:0]};
		addr_pool[2] = {~addr_pool[0][eabt_pkg::ADDR_W-1:16], addr_pool[0][15:0]};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// Empty table: address zero equals the cleared contents but must not hit.
		send_word(eabt_pkg::CMD_QUERY, '0, '0, '0);
		// Zero-length ban at time zero leaves the slot free and never live.
		send_word(eabt_pkg::CMD_BAN, '0, '0, '0);
		send_word(eabt_pkg::CMD_QUERY, '0, '0, '0);
		// Largest everything: expiry saturates at the top of the time range.
		send_word(eabt_pkg::CMD_BAN, ADDR_MAX, SECS_MAX, eabt_pkg::TIME_MAX);
		send_word(eabt_pkg::CMD_QUERY, ADDR_MAX, '0, eabt_pkg::TIME_MAX - 31'd1);
		send_word(eabt_pkg::CMD_QUERY, ADDR_MAX, SECS_MAX, eabt_pkg::TIME_MAX);
		// Same IP, other port must not match; expiry equal to now is not live.
		send_word(eabt_pkg::CMD_BAN, 48'hC0A8_0001_1F90, 20'd2, 31'd1000);
		send_word(eabt_pkg::CMD_QUERY, 48'hC0A8_0001_1F91, '0, 31'd1000);
		send_word(eabt_pkg::CMD_QUERY, 48'hC0A8_0001_1F90, '0, 31'd3000);
		// Expiry equal to now does not free the slot for a ban either.
		send_word(eabt_pkg::CMD_BAN, 48'hC0A8_0001_1F91, 20'd1, 31'd3000);
		// Fill the rest with one shared expiry to set up a tie.
		for (int i = 3; i < SLOTS; i++)
			send_word(eabt_pkg::CMD_BAN, {32'h0A00_0000 + 32'(i), 16'(i)}, 20'd5,
				31'd3000);
		// Full table: evict earliest, then next earliest, then lowest index of a tie.
		send_word(eabt_pkg::CMD_BAN, 48'h0102_0304_0506, 20'd7, 31'd3000);
		send_word(eabt_pkg::CMD_BAN, 48'h0708_090A_0B0C, 20'd7, 31'd3000);
		send_word(eabt_pkg::CMD_BAN, 48'h0D0E_0F10_1112, 20'd7, 31'd3000);
		send_word(eabt_pkg::CMD_QUERY, 48'hC0A8_0001_1F90, '0, 31'd3000);
		clock_ms = 31'd3000;

		// Random part in three idle profiles; the last runs flat out.
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n == RANDOM_REQS / 3) begin
				idle_pct  = 59;
				stall_pct = 22;
			end else if (n == 2 * RANDOM_REQS / 3) begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			random_request();
		end
		in_valid <= 1'b0;

		// Drain: wait for every owed verdict, then give stray words time to show.
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (2 * (SLOTS + 4)) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
